[sv/vtp_pkg.sv]
// shared types for the vertex transform and projection block
// no dependencies
package vtp_pkg;

    localparam int unsigned NumEntries = 12;

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_VERTEX = 1'b1
    } req_kind_t;

    typedef enum logic [2:0] {
        REG_CURRENT_FRAME = 3'd0
    } reg_addr_t;

    typedef struct packed {
        logic               valid;
        req_kind_t          kind;
        logic [3:0]         idx;
        logic signed [31:0] value;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               match;
        logic               last;
    } vtp_req_t;

    typedef struct packed {
        logic               valid;
        logic               visible;
        logic               last;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } vtp_view_t;

    typedef struct packed {
        logic               valid;
        logic               visible;
        logic               behind;
        logic               last;
        logic               neg_x;
        logic               neg_y;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } vtp_side_t;

endpackage

[sv/vtp_xform.sv]
// matrix store, multiply stage and saturating sum stage
// depends on vtp_pkg
module vtp_xform #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  vtp_pkg::vtp_req_t  req,
    output vtp_pkg::vtp_view_t view
);
    import vtp_pkg::*;

    logic signed [31:0] mat_reg [NumEntries];
    vtp_req_t           s1_reg;

    logic               s2_valid_reg, s2_vis_reg, s2_last_reg;
    logic signed [63:0] prod_reg [9];
    logic signed [31:0] trans_reg [3];

    vtp_view_t          s3_reg;
    logic signed [65:0] sum_next [3];
    logic signed [31:0] clamp_next [3];

    // request register; loads update the matrix as they leave it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            for (int i = 0; i < NumEntries; i++) begin
                mat_reg[i] <= '0;
            end
        end else if (en) begin
            s1_reg <= req;
            if (s1_reg.valid && s1_reg.kind == REQ_LOAD && s1_reg.idx < 4'(NumEntries)) begin
                mat_reg[s1_reg.idx] <= s1_reg.value;
            end
        end
    end

    // nine products, floor shift by the fraction width
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_reg.valid && s1_reg.kind == REQ_VERTEX;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_vis_reg  <= s1_reg.match;
            s2_last_reg <= s1_reg.last;
            for (int r = 0; r < 3; r++) begin
                prod_reg[r*3+0] <= (mat_reg[r*4+0] * 64'(s1_reg.x)) >>> FRAC_BITS;
                prod_reg[r*3+1] <= (mat_reg[r*4+1] * 64'(s1_reg.y)) >>> FRAC_BITS;
                prod_reg[r*3+2] <= (mat_reg[r*4+2] * 64'(s1_reg.z)) >>> FRAC_BITS;
                trans_reg[r]    <= mat_reg[r*4+3];
            end
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum_next[r] = 66'(prod_reg[r*3+0]) + 66'(prod_reg[r*3+1])
                        + 66'(prod_reg[r*3+2]) + 66'(trans_reg[r]);
            if (sum_next[r] > 66'sd2147483647) begin
                clamp_next[r] = 32'sh7fff_ffff;
            end else if (sum_next[r] < -66'sd2147483648) begin
                clamp_next[r] = 32'sh8000_0000;
            end else begin
                clamp_next[r] = sum_next[r][31:0];
            end
            if (!s2_vis_reg) begin
                clamp_next[r] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_reg.valid <= 1'b0;
        end else if (en) begin
            s3_reg.valid <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_reg.visible <= s2_vis_reg;
            s3_reg.last    <= s2_last_reg;
            s3_reg.vx      <= clamp_next[0];
            s3_reg.vy      <= clamp_next[1];
            s3_reg.vz      <= clamp_next[2];
        end
    end

    assign view = s3_reg;

endmodule

[sv/vtp_div.sv]
// pipelined restoring divider, one quotient bit per stage
// unsigned magnitudes; depends on vtp_pkg
module vtp_div #(
    parameter int unsigned NB = 48
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NB-1:0] num,
    input  logic [30:0]   den,
    output logic [NB-1:0] quo
);
    import vtp_pkg::*;

    logic [NB-1:0] num_reg [NB];
    logic [NB-1:0] q_reg   [NB];
    logic [31:0]   rem_reg [NB];
    logic [30:0]   den_reg [NB];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [NB-1:0] n_in, q_in, q_next;
        logic [31:0]   r_in, trial, r_next;
        logic [30:0]   d_in;
        logic          ge;

        if (k == 0) begin : g_first
            assign n_in = num;
            assign q_in = '0;
            assign r_in = '0;
            assign d_in = den;
        end else begin : g_rest
            assign n_in = num_reg[k-1];
            assign q_in = q_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign d_in = den_reg[k-1];
        end

        always_comb begin
            trial  = {r_in[30:0], n_in[NB-1-k]};
            ge     = trial >= {1'b0, d_in};
            r_next = ge ? trial - {1'b0, d_in} : trial;
            q_next = q_in;
            q_next[NB-1-k] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[k] <= n_in;
                q_reg[k]   <= q_next;
                rem_reg[k] <= r_next;
                den_reg[k] <= d_in;
            end
        end
    end

    assign quo = q_reg[NB-1];

endmodule

[sv/vertex_transform_and_projection.sv]
// top level: stream ports, apb register, divider lanes and output register
// depends on vtp_pkg, vtp_xform, vtp_div
//
// Input stream s_*: tuser is the request kind (0 matrix load, 1 vertex), tlast
// marks the last vertex of an object, tdata carries the remaining fields.
// A load writes one entry of the 3x4 matrix and gives no result. A vertex
// gives one result on m_*: view point, x/z and y/z projection, visible and
// behind_camera flags in tuser, last marker in tlast.
// One request is taken every cycle while s_tready is high. On the way to m_tvalid
// a vertex passes the request register, then multiply, sum and saturate, one
// divider stage per quotient bit (32 + FRAC_BITS), and the output register.
// A load affects every vertex accepted after it.
// Reset clears the matrix, current_frame and all valid bits.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated.
// current_frame sits at apb address 0 and is to be written only while idle; not enforced.
module vertex_transform_and_projection #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // entry_index, entry_value, vertex_x, vertex_y, vertex_z, vertex_frame
    input  logic [151:0] s_tdata,
    // req_type
    input  logic [0:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // view_x, view_y, view_z, screen_x, screen_y
    output logic [159:0] m_tdata,
    // visible, behind_camera
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import vtp_pkg::*;

    localparam int unsigned NB = 32 + FRAC_BITS;

    logic [15:0]   frame_reg;
    logic          en;
    vtp_req_t      req;
    vtp_view_t     view;
    vtp_side_t     side_in;
    vtp_side_t     side_reg [NB];
    logic [31:0]   mag_x, mag_y;
    logic [30:0]   den;
    logic [NB-1:0] qx, qy;
    logic [31:0]   sx_next, sy_next;

    logic          m_valid_reg;
    logic [159:0]  m_data_reg;
    logic [1:0]    m_user_reg;
    logic          m_last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_CURRENT_FRAME) ? {16'd0, frame_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg <= '0;
        end else if (psel && penable && pwrite && paddr == REG_CURRENT_FRAME) begin
            frame_reg <= pwdata[15:0];
        end
    end

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_comb begin
        req.valid = s_tvalid;
        req.kind  = req_kind_t'(s_tuser[0]);
        req.idx   = s_tdata[3:0];
        req.value = s_tdata[35:4];
        req.x     = s_tdata[67:36];
        req.y     = s_tdata[99:68];
        req.z     = s_tdata[131:100];
        req.match = s_tdata[147:132] == frame_reg;
        req.last  = s_tlast;
    end

    vtp_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .req     (req),
        .view    (view)
    );

    always_comb begin
        side_in.valid   = view.valid;
        side_in.visible = view.visible;
        side_in.behind  = view.visible && view.vz <= 0;
        side_in.last    = view.last;
        side_in.neg_x   = view.vx[31];
        side_in.neg_y   = view.vy[31];
        side_in.vx      = view.vx;
        side_in.vy      = view.vy;
        side_in.vz      = view.vz;
        mag_x = view.vx[31] ? 32'(-view.vx) : 32'(view.vx);
        mag_y = view.vy[31] ? 32'(-view.vy) : 32'(view.vy);
        // non-positive z gets a dummy divisor, result is dropped later
        den   = (view.vz > 0) ? view.vz[30:0] : 31'd1;
    end

    vtp_div #(.NB(NB)) u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  ({mag_x, FRAC_BITS'(0)}),
        .den  (den),
        .quo  (qx)
    );

    vtp_div #(.NB(NB)) u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  ({mag_y, FRAC_BITS'(0)}),
        .den  (den),
        .quo  (qy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NB; k++) begin
                side_reg[k].valid <= 1'b0;
            end
        end else if (en) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < NB; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // sign and saturate the quotient magnitudes; zero for hidden or behind-camera vertices
    always_comb begin
        if (side_reg[NB-1].neg_x) begin
            sx_next = (qx[NB-1:31] != '0) ? 32'h8000_0000 : 32'(-qx[31:0]);
        end else begin
            sx_next = (qx[NB-1:31] != '0) ? 32'h7fff_ffff : qx[31:0];
        end
        if (side_reg[NB-1].neg_y) begin
            sy_next = (qy[NB-1:31] != '0) ? 32'h8000_0000 : 32'(-qy[31:0]);
        end else begin
            sy_next = (qy[NB-1:31] != '0) ? 32'h7fff_ffff : qy[31:0];
        end
        if (!side_reg[NB-1].visible || side_reg[NB-1].behind) begin
            sx_next = '0;
            sy_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= side_reg[NB-1].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= {sy_next, sx_next, side_reg[NB-1].vz,
                           side_reg[NB-1].vy, side_reg[NB-1].vx};
            m_user_reg <= {side_reg[NB-1].behind, side_reg[NB-1].visible};
            m_last_reg <= side_reg[NB-1].last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

[tb/sv/vtp_checker.sv]
// checker for vertex_transform_and_projection: watches both streams and the apb port,
// predicts each vertex result from its own matrix copy and compares field by field
// depends on vtp_pkg
module vtp_checker #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [151:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [159:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           error_count,
    output int           pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import vtp_pkg::*;

    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [31:0] sx;
        logic [31:0] sy;
        logic        visible;
        logic        behind;
        logic        last;
    } projected_t;

    logic signed [31:0] matrix_copy [NumEntries];
    logic [15:0]        frame_copy;
    projected_t         expected_q [$];

    function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic projected_t project_vertex(input logic [151:0] d, input logic last);
        projected_t p;
        logic signed [63:0] coord [3];
        logic signed [63:0] view [3];
        logic signed [63:0] acc;
        logic signed [127:0] q;
        logic signed [63:0] sq;
        p = '0;
        p.last = last;
        if (d[147:132] != frame_copy) return p;
        coord[0] = 64'(signed'(d[67:36]));
        coord[1] = 64'(signed'(d[99:68]));
        coord[2] = 64'(signed'(d[131:100]));
        for (int r = 0; r < 3; r++) begin
            acc = 64'(matrix_copy[r*4+3]);
            // arithmetic shift floors the exact product
            for (int c = 0; c < 3; c++)
                acc += (64'(matrix_copy[r*4+c]) * coord[c]) >>> FRAC_BITS;
            view[r] = sat32(acc);
        end
        p.vx = view[0][31:0];
        p.vy = view[1][31:0];
        p.vz = view[2][31:0];
        p.visible = 1'b1;
        if (view[2] <= 0) begin
            p.behind = 1'b1;
        end else begin
            q = (128'(view[0]) <<< FRAC_BITS) / 128'(view[2]);
            sq = sat32(64'(q));
            p.sx = sq[31:0];
            q = (128'(view[1]) <<< FRAC_BITS) / 128'(view[2]);
            sq = sat32(64'(q));
            p.sy = sq[31:0];
        end
        return p;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    assign pending_count = expected_q.size();

    initial error_count = 0;

    always @(posedge aclk) begin
        projected_t want;
        if (!aresetn) begin
            for (int i = 0; i < NumEntries; i++) matrix_copy[i] <= '0;
            frame_copy <= '0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == REG_CURRENT_FRAME)
                frame_copy <= pwdata[15:0];
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request waiting");
                    error_count++;
                end else begin
                    want = expected_q.pop_front();
                    compare_field("view_x", want.vx, m_tdata[31:0]);
                    compare_field("view_y", want.vy, m_tdata[63:32]);
                    compare_field("view_z", want.vz, m_tdata[95:64]);
                    compare_field("screen_x", want.sx, m_tdata[127:96]);
                    compare_field("screen_y", want.sy, m_tdata[159:128]);
                    compare_field("visible", want.visible, m_tuser[0]);
                    compare_field("behind_camera", want.behind, m_tuser[1]);
                    compare_field("last_out", want.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == REQ_LOAD) begin
                    if (s_tdata[3:0] < NumEntries)
                        matrix_copy[s_tdata[3:0]] <= s_tdata[35:4];
                end else begin
                    expected_q.push_back(project_vertex(s_tdata, s_tlast));
                end
            end
        end
    end
endmodule

[tb/sv/tb_top.sv]
// top of the vertex transform testbench: clock, reset, stimulus and verdict
// depends on vtp_pkg, vtp_checker and the vertex_transform_and_projection rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import vtp_pkg::*;

    localparam int unsigned FRAC_BITS = 16;
    localparam int LATENCY = FRAC_BITS + 36;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           error_count;
    int           pending_count;
    bit           calm_tail = 1'b0;
    logic [15:0]  frame_now = '0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    vertex_transform_and_projection #(.FRAC_BITS(FRAC_BITS)) dut (.*);

    vtp_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (.*);

    // receiver stalls in random bursts
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (!calm_tail && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk iff pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_request(input req_kind_t kind, input logic [151:0] data,
                                input logic last);
        if (!calm_tail && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge aclk iff s_tready);
    endtask

    task automatic load_entry(input logic [3:0] idx, input logic [31:0] value);
        send_request(REQ_LOAD, {116'b0, value, idx}, 1'b0);
    endtask

    task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [15:0] frame,
                               input logic last);
        send_request(REQ_VERTEX, {frame, z, y, x, 36'b0} | 152'($urandom), last);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
        endcase
    endfunction

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk iff pending_count == 0);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic set_frame(input logic [15:0] f);
        drain();
        apb_write(REG_CURRENT_FRAME, {16'b0, f});
        frame_now = f;
    endtask

    initial begin
        logic [31:0] x, y, z;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero matrix, frame 0, then a mismatched tag
        send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'd0, 1'b0);
        send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'hffff, 1'b1);
        // identity with z offset
        for (int i = 0; i < 12; i++)
            load_entry(4'(i), (i % 5 == 0) ? 32'h0001_0000 : 32'h0);
        load_entry(4'd11, 32'h0004_0000);
        load_entry(4'd13, 32'h7fff_ffff);  // out-of-range entry, no effect
        load_entry(4'd15, 32'h8000_0000);
        send_vertex(32'h0002_0000, 32'hfffe_0000, 32'h0001_0000, 16'd0, 1'b0);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'hfffc_0000, 16'd0, 1'b0); // z == 0
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 16'd0, 1'b1); // behind
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'hfffc_0001, 16'd0, 1'b0); // huge quotient
        load_entry(4'd0, 32'h7fff_ffff);
        load_entry(4'd1, 32'h7fff_ffff);
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 16'd0, 1'b1);        // saturated sum
        set_frame(16'hffff);
        send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'hffff, 1'b0);
        send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 16'h0000, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            set_frame(phase == 3 ? 16'h0000 : 16'($urandom));
            for (int n = 0; n < 370; n++) begin
                if (phase == 3 && n == 250) calm_tail = 1'b1;
                if ($urandom_range(0, 5) == 0) begin
                    load_entry(4'($urandom_range(0, 15)),
                               $urandom_range(0, 1) ? $urandom
                                   : 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16)));
                end else begin
                    x = rand_coord(); y = rand_coord(); z = rand_coord();
                    send_vertex(x, y, z,
                                $urandom_range(0, 3) == 0 ? 16'($urandom) : frame_now,
                                1'($urandom));
                end
            end
        end
        drain();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
